[rtl/cdu_pkg.sv]
// Package with the shared types, constants and calendar tables of the date unit.
`default_nettype none

package cdu_pkg;

  // Field widths of the request and result items.
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 7;
  localparam int DAY_W   = 7;
  localparam int OMON_W  = 4;
  localparam int ODAY_W  = 5;
  localparam int DOY_W   = 9;
  localparam int QTR_W   = 3;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USED_W = 68;

  // Year range and calendar constants.
  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd0;
  localparam logic [OMON_W-1:0]  MONTH_JAN  = 4'd1;
  localparam logic [OMON_W-1:0]  MONTH_FEB  = 4'd2;
  localparam logic [OMON_W-1:0]  MONTH_DEC  = 4'd12;
  localparam logic [ODAY_W-1:0]  DAY_FIRST  = 5'd1;
  localparam logic [ODAY_W-1:0]  DAY_DEC31  = 5'd31;
  localparam logic [DOY_W-1:0]   DAYS_LEAP  = 9'd366;
  localparam logic [DOY_W-1:0]   DAYS_COMMON = 9'd365;

  // Divisibility by 25 through the multiplicative inverse of 25 modulo 2^14:
  // y is a multiple of 25 exactly when (y * 7209) mod 2^14 <= 16383 / 25.
  localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

  // Result fields of one date, as carried in the output register.
  typedef struct packed {
    logic [ODAY_W-1:0] prev_day;
    logic [OMON_W-1:0] prev_month;
    logic [YEAR_W-1:0] prev_year;
    logic [ODAY_W-1:0] next_day;
    logic [OMON_W-1:0] next_month;
    logic [YEAR_W-1:0] next_year;
    logic [QTR_W-1:0]  quarter;
    logic [DOY_W-1:0]  days_remaining;
    logic [DOY_W-1:0]  day_of_year;
    logic              leap;
  } cdu_res_t;

  // Length of a month in a common year; zero for codes that are no month.
  function automatic logic [ODAY_W-1:0] month_days(input logic [OMON_W-1:0] m);
    logic [ODAY_W-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
      4'd2:                                        n = 5'd28;
      default:                                     n = 5'd0;
    endcase
    return n;
  endfunction

  // Days in the months before month m of a common year.
  function automatic logic [DOY_W-1:0] days_before(input logic [OMON_W-1:0] m);
    logic [DOY_W-1:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Quarter of the year for month m.
  function automatic logic [QTR_W-1:0] quarter_of(input logic [OMON_W-1:0] m);
    logic [QTR_W-1:0] q;
    unique case (m)
      4'd1, 4'd2, 4'd3:    q = 3'd1;
      4'd4, 4'd5, 4'd6:    q = 3'd2;
      4'd7, 4'd8, 4'd9:    q = 3'd3;
      4'd10, 4'd11, 4'd12: q = 3'd4;
      default:             q = 3'd0;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

[rtl/calendar_date_unit.sv]
// Gregorian date unit: validity, leap flag, ordinal day, quarter, next and previous dates.
// Pipeline: a request is held in the input register, then in the output register,
// before its result is offered. Throughput: one request per cycle; the two registers advance
// together whenever the output register is empty or being taken.
// Reset: rst_n is synchronous and active low; it empties both registers, payload is kept.
// Every request gives exactly one result.
`default_nettype none

module calendar_date_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Request channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: year[13:0], month[20:14], day[27:21], zero fill [31:28]
  input  wire logic [cdu_pkg::IN_DATA_W-1:0]  in_tdata,
  // Result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // Fields from bit 0: leap[0], day_of_year[9:1], days_remaining[18:10],
  // quarter[21:19], next_year[35:22], next_month[39:36], next_day[44:40],
  // prev_year[58:45], prev_month[62:59], prev_day[67:63], zero fill [71:68]
  output logic [cdu_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Fields from bit 0: valid_res[0]
  output logic                                out_tuser
);

  // Pipeline control.
  logic                              s1_vld_r;
  logic [cdu_pkg::YEAR_W-1:0]        s1_year_r;
  logic [cdu_pkg::MONTH_W-1:0]       s1_month_r;
  logic [cdu_pkg::DAY_W-1:0]         s1_day_r;
  logic                              out_vld_r;
  logic                              out_valid_res_r;
  cdu_pkg::cdu_res_t                 out_res_r;
  logic                              adv;

  // Date decode signals.
  logic [cdu_pkg::OMON_W-1:0]        m4;
  logic [cdu_pkg::OMON_W-1:0]        m_prev;
  logic [cdu_pkg::ODAY_W-1:0]        d5;
  logic                              month_ok;
  logic [cdu_pkg::YEAR_W-1:0]        prod25;
  logic                              div4;
  logic                              div16;
  logic                              div25;
  logic                              leap;
  logic [cdu_pkg::ODAY_W-1:0]        mlen;
  logic [cdu_pkg::ODAY_W-1:0]        plen;
  logic                              valid_nxt;
  logic [cdu_pkg::DOY_W-1:0]         doy;
  logic [cdu_pkg::DOY_W-1:0]         total;
  cdu_pkg::cdu_res_t                 res;
  cdu_pkg::cdu_res_t                 res_nxt;

  // Both stages move whenever the output register is free or being drained.
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_tvalid) begin
      s1_year_r  <= in_tdata[13:0];
      s1_month_r <= in_tdata[20:14];
      s1_day_r   <= in_tdata[27:21];
    end
  end

  // Leap year: a multiple of 100 is a multiple of 4 and of 25, of 400 one of 16 and 25.
  assign prod25 = s1_year_r * cdu_pkg::INV25;
  assign div4   = (s1_year_r[1:0] == 2'd0);
  assign div16  = (s1_year_r[3:0] == 4'd0);
  assign div25  = (prod25 <= cdu_pkg::DIV25_LIM);
  assign leap   = div4 && (!div25 || div16);

  // Month length and the validity check.
  assign m4       = s1_month_r[3:0];
  assign m_prev   = m4 - 4'd1;
  assign d5       = s1_day_r[4:0];
  assign month_ok = (s1_month_r != 7'd0) && (s1_month_r <= 7'd12);
  assign mlen     = cdu_pkg::month_days(m4)
                    + {4'd0, (m4 == cdu_pkg::MONTH_FEB) && leap};
  assign plen     = cdu_pkg::month_days(m_prev)
                    + {4'd0, (m_prev == cdu_pkg::MONTH_FEB) && leap};
  assign valid_nxt = (s1_year_r <= cdu_pkg::YEAR_MAX) && month_ok
                     && (s1_day_r != 7'd0) && (s1_day_r <= {2'd0, mlen});

  // Ordinal day and days left in the year.
  assign doy   = cdu_pkg::days_before(m4) + {4'd0, d5}
                 + {8'd0, leap && (m4 > cdu_pkg::MONTH_FEB)};
  assign total = leap ? cdu_pkg::DAYS_LEAP : cdu_pkg::DAYS_COMMON;

  // Result fields of a valid date.
  always_comb begin
    res.leap           = leap;
    res.day_of_year    = doy;
    res.days_remaining = total - doy;
    res.quarter        = cdu_pkg::quarter_of(m4);

    // Following day: within the month, into the next month, or into the next year.
    priority if (d5 < mlen) begin
      res.next_year  = s1_year_r;
      res.next_month = m4;
      res.next_day   = d5 + 5'd1;
    end else if (m4 < cdu_pkg::MONTH_DEC) begin
      res.next_year  = s1_year_r;
      res.next_month = m4 + 4'd1;
      res.next_day   = cdu_pkg::DAY_FIRST;
    end else begin
      res.next_year  = (s1_year_r == cdu_pkg::YEAR_MAX) ? cdu_pkg::YEAR_MIN
                                                        : s1_year_r + 14'd1;
      res.next_month = cdu_pkg::MONTH_JAN;
      res.next_day   = cdu_pkg::DAY_FIRST;
    end

    // Preceding day: within the month, into the last month, or into the last year.
    priority if (d5 > cdu_pkg::DAY_FIRST) begin
      res.prev_year  = s1_year_r;
      res.prev_month = m4;
      res.prev_day   = d5 - 5'd1;
    end else if (m4 > cdu_pkg::MONTH_JAN) begin
      res.prev_year  = s1_year_r;
      res.prev_month = m_prev;
      res.prev_day   = plen;
    end else begin
      res.prev_year  = (s1_year_r == cdu_pkg::YEAR_MIN) ? cdu_pkg::YEAR_MAX
                                                        : s1_year_r - 14'd1;
      res.prev_month = cdu_pkg::MONTH_DEC;
      res.prev_day   = cdu_pkg::DAY_DEC31;
    end

    // An invalid date reports all fields as zero.
    res_nxt = valid_nxt ? res : '0;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      out_valid_res_r <= valid_nxt;
      out_res_r       <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_valid_res_r;
  assign out_tdata  = {{(cdu_pkg::OUT_DATA_W - cdu_pkg::OUT_USED_W){1'b0}}, out_res_r};

endmodule

`default_nettype wire

[rtl/cdu_checker.sv]
// Port-level checker for the date unit and its bind to the top level.
`default_nettype none

module cdu_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [cdu_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                          out_tuser
);

  // A stalled result keeps its place and its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An invalid date gives an all-zero result.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("invalid date with nonzero fields");

  // Ordinal day and days remaining add up to the length of the year.
  a_year_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (10'(out_tdata[9:1]) + 10'(out_tdata[18:10])) == (10'd365 + 10'(out_tdata[0])))
    else $error("day of year and days remaining disagree");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind calendar_date_unit cdu_checker u_cdu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

[sim/calendar_date_unit_tb.sv]
// Self-checking testbench for the Gregorian date unit, driven over its request and result streams.
`timescale 1ns / 1ps

module calendar_date_unit_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_DATES = 700;
  localparam int FILL_W = cdu_pkg::IN_DATA_W - cdu_pkg::YEAR_W - cdu_pkg::MONTH_W
                          - cdu_pkg::DAY_W;

  // Validity flag and result fields of one date, as one expectation.
  typedef struct packed {
    logic              valid;
    cdu_pkg::cdu_res_t res;
  } date_result_t;

  // One directed request; the expected result is typed in only when want_given is set.
  typedef struct {
    logic [cdu_pkg::YEAR_W-1:0]  year;
    logic [cdu_pkg::MONTH_W-1:0] month;
    logic [cdu_pkg::DAY_W-1:0]   day;
    bit                          want_given;
    date_result_t                want;
  } date_vector_t;

  localparam date_result_t NO_DATE = '0;

  localparam date_result_t FIRST_DAY_YEAR0 = '{valid: 1'b1, res: '{
    prev_day: 5'd31, prev_month: 4'd12, prev_year: 14'd9999,
    next_day: 5'd2, next_month: 4'd1, next_year: 14'd0,
    quarter: 3'd1, days_remaining: 9'd365, day_of_year: 9'd1, leap: 1'b1}};

  localparam date_result_t LAST_DAY_YEAR9999 = '{valid: 1'b1, res: '{
    prev_day: 5'd30, prev_month: 4'd12, prev_year: 14'd9999,
    next_day: 5'd1, next_month: 4'd1, next_year: 14'd0,
    quarter: 3'd4, days_remaining: 9'd0, day_of_year: 9'd365, leap: 1'b0}};

  // Directed dates: range ends, every way a date can be invalid, leap rules, quarters.
  date_vector_t directed_dates [0:24] = '{
    '{14'd0,     7'd1,   7'd1,   1'b1, FIRST_DAY_YEAR0},
    '{14'd9999,  7'd12,  7'd31,  1'b1, LAST_DAY_YEAR9999},
    '{14'd10000, 7'd1,   7'd1,   1'b1, NO_DATE},
    '{14'd16383, 7'd127, 7'd127, 1'b1, NO_DATE},
    '{14'd0,     7'd0,   7'd0,   1'b1, NO_DATE},
    '{14'd2000,  7'd0,   7'd1,   1'b1, NO_DATE},
    '{14'd2000,  7'd13,  7'd1,   1'b1, NO_DATE},
    '{14'd2000,  7'd1,   7'd0,   1'b1, NO_DATE},
    '{14'd2000,  7'd1,   7'd32,  1'b1, NO_DATE},
    '{14'd2001,  7'd2,   7'd29,  1'b1, NO_DATE},
    '{14'd1900,  7'd2,   7'd29,  1'b1, NO_DATE},
    '{14'd2001,  7'd4,   7'd31,  1'b1, NO_DATE},
    '{14'd2000,  7'd2,   7'd29,  1'b0, NO_DATE},
    '{14'd2004,  7'd2,   7'd29,  1'b0, NO_DATE},
    '{14'd2024,  7'd3,   7'd1,   1'b0, NO_DATE},
    '{14'd2023,  7'd3,   7'd1,   1'b0, NO_DATE},
    '{14'd2100,  7'd3,   7'd1,   1'b0, NO_DATE},
    '{14'd2023,  7'd12,  7'd31,  1'b0, NO_DATE},
    '{14'd2024,  7'd1,   7'd1,   1'b0, NO_DATE},
    '{14'd2024,  7'd12,  7'd31,  1'b0, NO_DATE},
    '{14'd0,     7'd12,  7'd31,  1'b0, NO_DATE},
    '{14'd9999,  7'd1,   7'd1,   1'b0, NO_DATE},
    '{14'd2023,  7'd4,   7'd30,  1'b0, NO_DATE},
    '{14'd2023,  7'd7,   7'd15,  1'b0, NO_DATE},
    '{14'd2023,  7'd10,  7'd1,   1'b0, NO_DATE}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [cdu_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [cdu_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;

  date_result_t expected_dates[$];
  bit           no_gaps;
  int           cycle_count;
  int           error_count;
  int           requests_sent;
  int           valid_dates_seen;
  int           invalid_dates_seen;

  calendar_date_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // Length of month m (1 to 12) in year y.
  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    case (m)
      2:            return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // Works out validity, leap flag, ordinal day, days remaining, quarter and both neighboring dates of one date.
  function automatic date_result_t predict_date(int unsigned y, int unsigned m, int unsigned d);
    date_result_t r;
    int unsigned  ordinal;
    bit           lp;
    r = '0;
    if (y > cdu_pkg::YEAR_MAX || m < 1 || m > 12 || d < 1 || d > month_length(y, m)) return r;
    lp = is_leap_year(y);
    ordinal = d;
    for (int unsigned k = 1; k < m; k++) ordinal += month_length(y, k);
    r.valid              = 1'b1;
    r.res.leap           = lp;
    r.res.day_of_year    = 9'(ordinal);
    r.res.days_remaining = 9'((lp ? 366 : 365) - ordinal);
    r.res.quarter        = 3'((m - 1) / 3 + 1);

    // Following day: within the month, into the next month, or into the next year.
    if (d < month_length(y, m)) begin
      r.res.next_year = 14'(y); r.res.next_month = 4'(m); r.res.next_day = 5'(d + 1);
    end else if (m < 12) begin
      r.res.next_year = 14'(y); r.res.next_month = 4'(m + 1); r.res.next_day = 5'd1;
    end else begin
      r.res.next_year = (y == cdu_pkg::YEAR_MAX) ? cdu_pkg::YEAR_MIN : 14'(y + 1);
      r.res.next_month = 4'd1; r.res.next_day = 5'd1;
    end

    // Preceding day, wrapping from the first day of year 0 to the end of the range.
    if (d > 1) begin
      r.res.prev_year = 14'(y); r.res.prev_month = 4'(m); r.res.prev_day = 5'(d - 1);
    end else if (m > 1) begin
      r.res.prev_year = 14'(y); r.res.prev_month = 4'(m - 1);
      r.res.prev_day = 5'(month_length(y, m - 1));
    end else begin
      r.res.prev_year = (y == cdu_pkg::YEAR_MIN) ? cdu_pkg::YEAR_MAX : 14'(y - 1);
      r.res.prev_month = 4'd12; r.res.prev_day = 5'd31;
    end
    return r;
  endfunction

  // Offers one date, with a random gap first unless no_gaps is set, and records what it must produce.
  task automatic send_date(input logic [cdu_pkg::YEAR_W-1:0] y,
                           input logic [cdu_pkg::MONTH_W-1:0] m,
                           input logic [cdu_pkg::DAY_W-1:0] d, input bit want_given,
                           input date_result_t want);
    while (!no_gaps && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{FILL_W{1'b0}}, d, m, y};
    do @(posedge clk); while (!in_tready);
    expected_dates.push_back(want_given ? want : predict_date(y, m, d));
    requests_sent++;
  endtask

  // Random date: mostly well-formed with month ends and range ends favored,
  // then near misses, then raw noise over the full field widths.
  task automatic pick_date(output logic [cdu_pkg::YEAR_W-1:0] y,
                           output logic [cdu_pkg::MONTH_W-1:0] m,
                           output logic [cdu_pkg::DAY_W-1:0] d);
    int unsigned shape;
    int unsigned len;
    shape = $urandom_range(99);
    case ($urandom_range(9))
      0:       y = cdu_pkg::YEAR_MIN;
      1:       y = cdu_pkg::YEAR_MAX;
      2:       y = 14'(100 * $urandom_range(99));
      default: y = 14'($urandom_range(9999));
    endcase
    m = 7'($urandom_range(12, 1));
    len = month_length(y, m);
    if (shape < 75) begin
      case ($urandom_range(4))
        0:       d = 7'(len);
        1:       d = 7'd1;
        default: d = 7'($urandom_range(len, 1));
      endcase
    end else if (shape < 88) begin
      d = 7'($urandom_range(len, 1));
      case ($urandom_range(3))
        0:       d = 7'd0;
        1:       d = 7'(len + 1);
        2:       m = ($urandom_range(1) != 0) ? 7'd0 : 7'd13;
        default: y = 14'($urandom_range(16383, 10000));
      endcase
    end else begin
      y = 14'($urandom_range(16383));
      m = 7'($urandom_range(127));
      d = 7'($urandom_range(127));
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Result side stalls at random except during the burst stretch.
  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    date_result_t      want;
    cdu_pkg::cdu_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = cdu_pkg::cdu_res_t'(out_tdata[cdu_pkg::OUT_USED_W-1:0]);
      if (expected_dates.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %b", out_tdata, out_tuser);
        error_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("valid_res", want.valid, out_tuser);
        check_field("leap", want.res.leap, got.leap);
        check_field("day_of_year", want.res.day_of_year, got.day_of_year);
        check_field("days_remaining", want.res.days_remaining, got.days_remaining);
        check_field("quarter", want.res.quarter, got.quarter);
        check_field("next_year", want.res.next_year, got.next_year);
        check_field("next_month", want.res.next_month, got.next_month);
        check_field("next_day", want.res.next_day, got.next_day);
        check_field("prev_year", want.res.prev_year, got.prev_year);
        check_field("prev_month", want.res.prev_month, got.prev_month);
        check_field("prev_day", want.res.prev_day, got.prev_day);
        check_field("zero fill", 0, out_tdata[cdu_pkg::OUT_DATA_W-1:cdu_pkg::OUT_USED_W]);
        if (want.valid) valid_dates_seen++;
        else invalid_dates_seen++;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("calendar_date_unit: mismatch");
    $finish;
  end

  // Main sequence: reset, directed table, random dates, drain.
  initial begin
    logic [cdu_pkg::YEAR_W-1:0]  y;
    logic [cdu_pkg::MONTH_W-1:0] m;
    logic [cdu_pkg::DAY_W-1:0]   d;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    no_gaps     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_dates[i]) begin
      send_date(directed_dates[i].year, directed_dates[i].month, directed_dates[i].day,
                directed_dates[i].want_given, directed_dates[i].want);
    end

    for (int i = 0; i < RANDOM_DATES; i++) begin
      // Once, hold the requests back until the unit has drained.
      if (i == 300) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_dates.size() != 0) @(posedge clk);
      end
      no_gaps = (i >= 400 && i < 520);
      pick_date(y, m, d);
      send_date(y, m, d, 1'b0, NO_DATE);
    end
    in_tvalid <= 1'b0;
    no_gaps = 1'b0;

    while (expected_dates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d dates; checked %0d valid and %0d invalid results.",
             requests_sent, valid_dates_seen, invalid_dates_seen);
    $display("Covered range ends, leap rules, month and year rollovers and malformed fields.");
    if (error_count == 0) begin
      $display("calendar_date_unit: match");
    end else begin
      $display("calendar_date_unit: mismatch");
    end
    $finish;
  end

endmodule

[calendar_date_unit.f]
rtl/cdu_pkg.sv
rtl/calendar_date_unit.sv
rtl/cdu_checker.sv
sim/calendar_date_unit_tb.sv
